// ----- hw/rtl/ssa_pkg.sv -----
// ssa_pkg: shared constants for the segment selector allocator.
// Holds the free-map row geometry, the result status codes, the request kinds and the descriptor constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssa_pkg;

    // Free map row geometry: one memory word holds this many slot bits
    localparam int ROW_W  = 64;
    localparam int ROW_BW = 6;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Descriptor constants
    localparam logic [4:0]  SEG_TYPE       = 5'h13;
    localparam logic [1:0]  SEG_DPL        = 2'd3;
    localparam logic [31:0] GRAN_THRESHOLD = 32'h0010_0000;

endpackage

`default_nettype wire

// ----- hw/rtl/ssa_free_map.sv -----
// ssa_free_map: free-slot bitmap stored as rows of ROW_W bits in a memory.
// Per-row valid and full flags give the reset state and the row summary.
// Depends on ssa_pkg for the row geometry.
`default_nettype none

module ssa_free_map
    import ssa_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int ROWS    = 4,
    parameter int ROW_AW  = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ROW_AW-1:0] rd_row,
    output logic      [ROW_W-1:0]  rd_word,
    input  wire logic              wr_en,
    input  wire logic [ROW_AW-1:0] wr_row,
    input  wire logic [ROW_W-1:0]  wr_word,
    output logic      [ROWS-1:0]   row_full
);

    // Valid bits in the last row; bits past ENTRIES are never free
    localparam int LAST_BITS = ENTRIES - (ROWS - 1) * ROW_W;
    localparam logic [ROW_W-1:0] ALL_ONES  = {ROW_W{1'b1}};
    localparam logic [ROW_W-1:0] LAST_MASK = ALL_ONES >> (ROW_W - LAST_BITS);

    logic [ROW_W-1:0] mem [0:ROWS-1];
    logic [ROW_W-1:0] rd_word_reg;
    logic [ROWS-1:0]  row_valid_reg;
    logic [ROWS-1:0]  row_full_reg;
    logic [ROW_W-1:0] rd_mask;
    logic [ROW_W-1:0] wr_mask;
    logic [ROW_W-1:0] wr_masked;

    assign rd_mask   = (32'(rd_row) == ROWS - 1) ? LAST_MASK : ALL_ONES;
    assign wr_mask   = (32'(wr_row) == ROWS - 1) ? LAST_MASK : ALL_ONES;
    assign wr_masked = wr_word & wr_mask;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_masked;
        end
    end

    // Registered read; a row never written reads as all free
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (row_valid_reg[rd_row])
            begin
                rd_word_reg <= mem[rd_row] & rd_mask;
            end
            else
            begin
                rd_word_reg <= rd_mask;
            end
        end
    end

    // Row summary: written flag and no-free-slot flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_row] <= 1'b1;
            row_full_reg[wr_row]  <= (wr_masked == '0);
        end
    end

    assign rd_word  = rd_word_reg;
    assign row_full = row_full_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ssa_desc_build.sv -----
// ssa_desc_build: packs a 32-bit x86 data-segment descriptor from base and limit.
// Sets granularity and scales the limit by 4 KiB when the limit is 1 MiB or more.
// Depends on ssa_pkg for the type, privilege and threshold constants.
`default_nettype none

module ssa_desc_build
    import ssa_pkg::*;
(
    input  wire logic [31:0] base_addr,
    input  wire logic [31:0] limit_value,
    output logic      [31:0] desc_low,
    output logic      [31:0] desc_high
);

    logic        gran;
    logic [31:0] lim;

    // Pick byte or page granularity
    assign gran = (limit_value >= GRAN_THRESHOLD);
    assign lim  = gran ? (limit_value >> 12) : limit_value;

    // Pack low and high dwords
    assign desc_low  = {base_addr[15:0], lim[15:0]};
    assign desc_high = {base_addr[31:24], gran, 1'b1, 1'b0, 1'b0, lim[19:16],
                        1'b1, SEG_DPL, SEG_TYPE, base_addr[23:16]};

endmodule

`default_nettype wire

// ----- hw/rtl/segment_selector_allocator_top.sv -----
// segment_selector_allocator_top: first-free selector allocator with descriptor build.
// Depends on ssa_pkg, ssa_free_map and ssa_desc_build.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low.
//   req_type 0 allocates the lowest free slot x and returns selector x*8+15
//   with the packed data-segment descriptor for base_addr / limit_value.
//   req_type 1 releases slot (selector_in>>3)-1.
//   Each result appears on status, selector_out, desc_low and desc_high for
//   exactly one cycle with done high; the receiver cannot stall it.
// Sequencing:
//   Requests that read the map (allocate with a free slot, in-range free)
//   first read the row from the free-map memory, then modify the row and
//   write it back. done rises the cycle after write-back, and busy is low
//   again in that cycle, so the next request is accepted only then.
//   Allocate with no free slot and an out-of-range free finish at once: done
//   rises in the cycle after acceptance and busy stays low.
//   The row search uses one priority encoder over the per-row full flags and
//   one over the 64-bit row word read from memory.
// Reset:
//   rst_n clears the per-row valid flags, so every slot reads free; no
//   clearing pass is needed.
`default_nettype none

module segment_selector_allocator_top
    import ssa_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [31:0] base_addr,
    input  wire logic [31:0] limit_value,
    input  wire logic [15:0] selector_in,
    output logic             done,
    output logic      [1:0]  status,
    output logic      [15:0] selector_out,
    output logic      [31:0] desc_low,
    output logic      [31:0] desc_high
);

    localparam int ROWS   = (ENTRIES + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_MODIFY = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic              req_reg;
    logic [ROW_AW-1:0] row_reg;
    logic [ROW_BW-1:0] bit_reg;
    logic [31:0]       base_reg;
    logic [31:0]       limit_reg;

    logic              done_reg;
    logic [1:0]        status_reg;
    logic [15:0]       selector_reg;
    logic [31:0]       desc_low_reg;
    logic [31:0]       desc_high_reg;

    logic              accept;
    logic [ROWS-1:0]   row_full;
    logic              any_row;
    logic [ROW_AW-1:0] free_row;
    logic [12:0]       hi_idx;
    logic [12:0]       slot_idx;
    logic [12:0]       slot_row;
    logic              free_ok;
    logic [ROW_AW-1:0] rd_row;
    logic              start_map;

    logic [ROW_W-1:0]  rd_word;
    logic [ROW_W-1:0]  wr_word;
    logic              wr_en;
    logic [ROW_BW-1:0] first_bit;
    logic [31:0]       d_low;
    logic [31:0]       d_high;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Find the first row that still has a free slot
    always_comb
    begin
        any_row  = 1'b0;
        free_row = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (!row_full[r])
            begin
                any_row  = 1'b1;
                free_row = ROW_AW'(r);
            end
        end
    end

    // Decode the selector to release
    assign hi_idx   = selector_in[15:3];
    assign slot_idx = hi_idx - 13'd1;
    assign slot_row = slot_idx >> ROW_BW;
    assign free_ok  = (hi_idx != 13'd0) && (32'(hi_idx) <= ENTRIES);

    assign rd_row    = (req_type == REQ_ALLOC) ? free_row : slot_row[ROW_AW-1:0];
    assign start_map = accept && ((req_type == REQ_ALLOC) ? any_row : free_ok);

    // Lowest free bit of the fetched row
    always_comb
    begin
        first_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (rd_word[b])
            begin
                first_bit = ROW_BW'(b);
            end
        end
    end

    // Modify the row: clear for allocate, set for free
    always_comb
    begin
        wr_word = rd_word;
        if (req_reg == REQ_ALLOC)
        begin
            wr_word[first_bit] = 1'b0;
        end
        else
        begin
            wr_word[bit_reg] = 1'b1;
        end
    end

    assign wr_en = (state_reg == ST_MODIFY);

    ssa_free_map #(
        .ENTRIES (ENTRIES),
        .ROWS    (ROWS),
        .ROW_AW  (ROW_AW)
    ) u_free_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (start_map),
        .rd_row   (rd_row),
        .rd_word  (rd_word),
        .wr_en    (wr_en),
        .wr_row   (row_reg),
        .wr_word  (wr_word),
        .row_full (row_full)
    );

    ssa_desc_build u_desc_build (
        .base_addr   (base_reg),
        .limit_value (limit_reg),
        .desc_low    (d_low),
        .desc_high   (d_high)
    );

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = start_map ? ST_MODIFY : ST_IDLE;
            ST_MODIFY: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (accept && !start_map) || (state_reg == ST_MODIFY);
        end
    end

    // Hold the request fields for the modify cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            row_reg   <= rd_row;
            bit_reg   <= slot_idx[ROW_BW-1:0];
            base_reg  <= base_addr;
            limit_reg <= limit_value;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (accept && !start_map)
        begin
            status_reg    <= (req_type == REQ_ALLOC) ? STAT_FULL : STAT_RANGE;
            selector_reg  <= '0;
            desc_low_reg  <= '0;
            desc_high_reg <= '0;
        end
        else if (state_reg == ST_MODIFY)
        begin
            status_reg <= STAT_OK;
            if (req_reg == REQ_ALLOC)
            begin
                selector_reg  <= (16'({row_reg, first_bit}) << 3) + 16'd15;
                desc_low_reg  <= d_low;
                desc_high_reg <= d_high;
            end
            else
            begin
                selector_reg  <= '0;
                desc_low_reg  <= '0;
                desc_high_reg <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign selector_out = selector_reg;
    assign desc_low     = desc_low_reg;
    assign desc_high    = desc_high_reg;

    // A result follows either a finished modify or an immediate error
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_MODIFY) || $past(accept))
        else $error("done without a preceding transaction");

    // The modify state follows an accepted transaction and is left in the next cycle
    a_modify_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY) |-> $past(accept) ##1 (state_reg == ST_IDLE))
        else $error("modify cycle not bounded to one cycle");

    // Allocated selectors always carry TI set and RPL 3
    a_sel_form: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_OK && selector_out != 16'd0)
            |-> (selector_out[2:0] == 3'b111))
        else $error("allocated selector malformed");

endmodule

`default_nettype wire

// ----- test/segment_selector_allocator_top_tb.sv -----
// Testbench for segment_selector_allocator_top: allocate and free transactions
// are checked against a scoreboard that tracks the slot map and packs descriptors.
// Depends on ssa_pkg and segment_selector_allocator_top.
`timescale 1ns / 1ps

module segment_selector_allocator_top_tb;
    import ssa_pkg::*;

    localparam int SLOTS          = 256;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] selector;
        logic [31:0] lo;
        logic [31:0] hi;
    } seg_result_t;

    // Track the slot map and the results still owed by the block
    class selector_scoreboard;
        bit [SLOTS-1:0] slot_free;
        seg_result_t    pending_q[$];
        int             errors;

        function new();
            slot_free = '1;
            errors    = 0;
        endfunction

        // Predict the result of an accepted request and update the map
        function void note_request(logic req, logic [31:0] base, logic [31:0] lim,
                                   logic [15:0] sel);
            seg_result_t r;
            int          x;
            int          idx;
            logic        gran;
            logic [31:0] seg_lim;
            r = '0;
            if (req == REQ_ALLOC) begin
                x = SLOTS;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_free[i])
                        x = i;
                if (x == SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    gran         = (lim >= GRAN_THRESHOLD);
                    seg_lim      = gran ? (lim >> 12) : lim;
                    slot_free[x] = 1'b0;
                    r.status     = STAT_OK;
                    r.selector   = 16'(x * 8 + 15);
                    r.lo         = {base[15:0], seg_lim[15:0]};
                    r.hi         = {base[31:24], gran, 1'b1, 1'b0, 1'b0, seg_lim[19:16],
                                    1'b1, SEG_DPL, SEG_TYPE, base[23:16]};
                end
            end else begin
                idx = int'(sel >> 3);
                if (idx == 0 || idx - 1 >= SLOTS)
                    r.status = STAT_RANGE;
                else
                    slot_free[idx - 1] = 1'b1;
            end
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_result(logic [1:0] st, logic [15:0] sel, logic [31:0] lo,
                                   logic [31:0] hi);
            seg_result_t e;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h %h %h %h",
                         $time, st, sel, lo, hi);
                return;
            end
            e = pending_q.pop_front();
            compare_field("status", 32'(e.status), 32'(st));
            compare_field("selector_out", 32'(e.selector), 32'(sel));
            compare_field("desc_low", e.lo, lo);
            compare_field("desc_high", e.hi, hi);
        endfunction

        // Return some used slot, or -1 when every slot is free
        function int pick_used_slot();
            int first;
            int i;
            first = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++) begin
                i = (first + k) % SLOTS;
                if (!slot_free[i])
                    return i;
            end
            return -1;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [31:0] base_addr;
    logic [31:0] limit_value;
    logic [15:0] selector_in;
    logic        done;
    logic [1:0]  status;
    logic [15:0] selector_out;
    logic [31:0] desc_low;
    logic [31:0] desc_high;

    selector_scoreboard sb = new();
    int                 idle_cycles = 0;

    segment_selector_allocator_top #(
        .ENTRIES (SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .base_addr    (base_addr),
        .limit_value  (limit_value),
        .selector_in  (selector_in),
        .done         (done),
        .status       (status),
        .selector_out (selector_out),
        .desc_low     (desc_low),
        .desc_high    (desc_high)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Sample accepted requests and results; stop the run when nothing moves
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request(req_type, base_addr, limit_value, selector_in);
        if (rst_n && done)
            sb.check_result(status, selector_out, desc_low, desc_high);
        if ((rst_n && start && !busy) || (rst_n && done)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted
    task automatic send(logic req, logic [31:0] base, logic [31:0] lim, logic [15:0] sel);
        @(negedge clk);
        start       <= 1'b1;
        req_type    <= req;
        base_addr   <= base;
        limit_value <= lim;
        selector_in <= sel;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle(int n);
        if (n > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Hold off until every predicted result has arrived
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix small, large and threshold-adjacent limits
    function automatic logic [31:0] random_limit();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return GRAN_THRESHOLD - 32'd2 + 32'($urandom_range(0, 3));
            default: return 32'($urandom_range(0, 32'h000F_FFFF));
        endcase
    endfunction

    // Pick a selector to release: mostly live ones, some noise and edge values
    function automatic logic [15:0] free_selector();
        int r;
        int x;
        r = $urandom_range(0, 99);
        x = sb.pick_used_slot();
        if (r < 80 && x >= 0)
            return 16'((x + 1) * 8 + $urandom_range(0, 7));
        if (r < 90)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 7));
            1: return 16'((SLOTS + 1) * 8 + $urandom_range(0, 7));
            2: return 16'hFFFF;
            default: return 16'($urandom_range(1, SLOTS) * 8 + $urandom_range(0, 7));
        endcase
    endfunction

    task automatic run_phase(int n, int alloc_pct, bit with_gaps);
        for (int k = 0; k < n; k++) begin
            if (with_gaps)
                idle(gap_length());
            if ($urandom_range(0, 99) < alloc_pct)
                send(REQ_ALLOC, $urandom, random_limit(), 16'($urandom));
            else
                send(REQ_FREE, $urandom, $urandom, free_selector());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_ALLOC;
        base_addr   = '0;
        limit_value = '0;
        selector_in = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, granularity threshold, range errors, double free
        send(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        send(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send(REQ_ALLOC, 32'h1234_5678, 32'h000F_FFFF, 16'h0000);
        send(REQ_ALLOC, 32'h89AB_CDEF, 32'h0010_0000, 16'h0000);
        send(REQ_ALLOC, 32'h00FF_0000, 32'h0000_0001, 16'h0000);
        send(REQ_FREE, 32'h0, 32'h0, 16'd0);
        send(REQ_FREE, 32'h0, 32'h0, 16'd7);
        send(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd8);
        send(REQ_FREE, 32'h0, 32'h0, 16'd15);
        send(REQ_ALLOC, 32'hA5A5_5A5A, 32'h7FFF_FFFF, 16'h0000);
        send(REQ_FREE, 32'h0, 32'h0, 16'((SLOTS + 1) * 8 - 1));
        send(REQ_FREE, 32'h0, 32'h0, 16'((SLOTS + 1) * 8));
        send(REQ_FREE, 32'h0, 32'h0, 16'hFFFF);
        send(REQ_FREE, 32'h0, 32'h0, 16'd16);
        send(REQ_FREE, 32'h0, 32'h0, 16'd31);
        send(REQ_ALLOC, 32'h0001_0000, 32'h000F_FFFF, 16'h0000);
        send(REQ_ALLOC, 32'h0100_0000, 32'h0010_0FFF, 16'h0000);
        send(REQ_FREE, 32'h0, 32'h0, 16'd40);

        // Random: fill past full, drain, mix, refill and drain again
        run_phase(360, 92, 1'b1);
        drain_results();
        run_phase(360, 15, 1'b0);
        run_phase(300, 50, 1'b1);
        run_phase(300, 90, 1'b0);
        run_phase(230, 20, 1'b1);

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
